/* rtl/core/ffa_pkg.sv */
// -----------------------------------------------------------------------------
// ffa_pkg
// Shared types and constants of the first-fit free-list allocator.
// -----------------------------------------------------------------------------
package ffa_pkg;

	localparam int unsigned ALIGN_BYTES  = 16;   // power of two
	localparam int unsigned HEADER_BYTES = 16;

	localparam logic [23:0] POOL_RESET = 24'(14 * 1024 * 1024);
	localparam logic [24:0] ALIGN_LOW  = 25'(ALIGN_BYTES - 1);
	localparam logic [25:0] HEADER_W   = 26'(HEADER_BYTES);

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_OOM     = 3'd1,
		ST_ZERO    = 3'd2,
		ST_FULL    = 3'd3,
		ST_UNKNOWN = 3'd4,
		ST_DOUBLE  = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		SRC_NONE = 2'd0,
		SRC_HIT  = 2'd1,
		SRC_NEW  = 2'd2
	} res_src_t;

	localparam logic KIND_ALLOC = 1'b0;

	typedef struct packed {
		logic     in_ready;
		logic     load;
		logic     init;
		logic     advance;
		logic     unlink;
		logic     alloc_new;
		logic     release_blk;
		logic     wr_res;
		status_t  st;
		res_src_t src;
		logic     emit;
	} cmd_t;

	typedef struct packed {
		logic in_valid;
		logic kind;
		logic zero_req;
		logic addr_zero;
		logic cur_in_range;
		logic fit;
		logic match;
		logic hit_free;
		logic no_room;
		logic table_full;
		logic out_free;
	} sts_t;

endpackage

/* rtl/core/ffa_if.sv */
// -----------------------------------------------------------------------------
// ffa_req_if / ffa_rsp_if
// Valid/ready channels for requests and results.
// -----------------------------------------------------------------------------
interface ffa_req_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [23:0] request_size;
	logic [23:0] release_address;

	modport source (output valid, kind, request_size, release_address, input ready);
	modport sink   (input valid, kind, request_size, release_address, output ready);
endinterface

interface ffa_rsp_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [23:0] payload_address;
	logic [23:0] granted_size;

	modport source (output valid, status, payload_address, granted_size, input ready);
	modport sink   (input valid, status, payload_address, granted_size, output ready);
endinterface

/* rtl/core/ffa_ctrl.sv */
// -----------------------------------------------------------------------------
// ffa_ctrl
// Sequencer: decodes a request, walks the free list or scans the block table.
// -----------------------------------------------------------------------------
module ffa_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  ffa_pkg::sts_t sts,
	output ffa_pkg::cmd_t cmd
);

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_START = 6'b000010,
		S_ISSUE = 6'b000100,
		S_CHECK = 6'b001000,
		S_BUMP  = 6'b010000,
		S_EMIT  = 6'b100000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		cmd = '0;
		cmd.st = ffa_pkg::ST_OK;
		cmd.src = ffa_pkg::SRC_NONE;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				cmd.in_ready = 1'b1;
				if (sts.in_valid) begin
					cmd.load = 1'b1;
					state_d = S_START;
				end
			end
			S_START: begin
				// hold off until the previous result has left the output register
				if (sts.out_free) begin
					if (sts.kind == ffa_pkg::KIND_ALLOC && sts.zero_req) begin
						cmd.wr_res = 1'b1;
						cmd.st = ffa_pkg::ST_ZERO;
						state_d = S_EMIT;
					end else if (sts.kind != ffa_pkg::KIND_ALLOC && sts.addr_zero) begin
						cmd.wr_res = 1'b1;
						state_d = S_EMIT;
					end else begin
						cmd.init = 1'b1;
						state_d = S_ISSUE;
					end
				end
			end
			S_ISSUE: begin
				if (sts.cur_in_range) begin
					state_d = S_CHECK;
				end else if (sts.kind == ffa_pkg::KIND_ALLOC) begin
					state_d = S_BUMP;
				end else begin
					cmd.wr_res = 1'b1;
					cmd.st = ffa_pkg::ST_UNKNOWN;
					state_d = S_EMIT;
				end
			end
			S_CHECK: begin
				if (sts.kind == ffa_pkg::KIND_ALLOC) begin
					if (sts.fit) begin
						cmd.unlink = 1'b1;
						cmd.wr_res = 1'b1;
						cmd.src = ffa_pkg::SRC_HIT;
						state_d = S_EMIT;
					end else begin
						cmd.advance = 1'b1;
						state_d = S_ISSUE;
					end
				end else if (sts.match) begin
					cmd.wr_res = 1'b1;
					if (sts.hit_free) begin
						cmd.st = ffa_pkg::ST_DOUBLE;
					end else begin
						cmd.release_blk = 1'b1;
					end
					state_d = S_EMIT;
				end else begin
					cmd.advance = 1'b1;
					state_d = S_ISSUE;
				end
			end
			S_BUMP: begin
				cmd.wr_res = 1'b1;
				if (sts.no_room) begin
					cmd.st = ffa_pkg::ST_OOM;
				end else if (sts.table_full) begin
					cmd.st = ffa_pkg::ST_FULL;
				end else begin
					cmd.alloc_new = 1'b1;
					cmd.src = ffa_pkg::SRC_NEW;
				end
				state_d = S_EMIT;
			end
			S_EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// a request is taken only when the sequencer is free
	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> state_q == S_START)
		else $error("load did not start a request");

	// every table write leads straight to the result beat
	a_commit_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.unlink || cmd.alloc_new || cmd.release_blk) |=> state_q == S_EMIT)
		else $error("commit without result");

	// the result slot is written exactly once per request before emitting
	a_wr_emit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_res |=> state_q == S_EMIT && !cmd.wr_res)
		else $error("result written twice");

endmodule

/* rtl/core/ffa_dp.sv */
// -----------------------------------------------------------------------------
// ffa_dp
// Datapath: block table memories, list pointers, bump pointer, result register.
// -----------------------------------------------------------------------------
module ffa_dp #(
	parameter int unsigned MAX_BLOCKS = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [23:0]        cfg_wdata,
	ffa_req_if.sink            req,
	ffa_rsp_if.source          rsp,
	input  ffa_pkg::cmd_t      cmd,
	output ffa_pkg::sts_t      sts
);

	localparam int unsigned AW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
	localparam int unsigned IW = $clog2(MAX_BLOCKS + 1);
	localparam logic [IW-1:0] NULL_IDX = IW'(MAX_BLOCKS);

	logic [23:0] off_mem   [MAX_BLOCKS];
	logic [23:0] bytes_mem [MAX_BLOCKS];
	logic [IW-1:0] next_mem [MAX_BLOCKS];
	logic        free_mem  [MAX_BLOCKS];

	logic [23:0]   off_rd_q, bytes_rd_q;
	logic [IW-1:0] next_rd_q;
	logic          free_rd_q;

	logic [23:0]   pool_q, bump_q;
	logic [IW-1:0] count_q, head_q, cur_q, prev_q;
	logic          prev_valid_q;
	logic          kind_q;
	logic [24:0]   rounded_q;
	logic [23:0]   req_size_q, addr_q;

	logic          out_valid_q;
	logic [2:0]    out_status_q;
	logic [23:0]   out_addr_q, out_size_q;

	logic [23:0]   left;
	logic [25:0]   need;
	logic [24:0]   payload_hit;
	logic [AW-1:0] cur_a, prev_a, cnt_a;

	assign cur_a  = cur_q[AW-1:0];
	assign prev_a = prev_q[AW-1:0];
	assign cnt_a  = count_q[AW-1:0];

	assign left = (bump_q <= pool_q) ? pool_q - bump_q : 24'd0;
	assign need = ffa_pkg::HEADER_W + {1'b0, rounded_q};
	assign payload_hit = {1'b0, off_rd_q} + ffa_pkg::HEADER_W[24:0];

	assign req.ready = cmd.in_ready;

	assign sts.in_valid     = req.valid;
	assign sts.kind         = kind_q;
	assign sts.zero_req     = (req_size_q == 24'd0);
	assign sts.addr_zero    = (addr_q == 24'd0);
	assign sts.cur_in_range = (cur_q < count_q);
	assign sts.fit          = ({1'b0, bytes_rd_q} >= rounded_q);
	assign sts.match        = (payload_hit == {1'b0, addr_q});
	assign sts.hit_free     = free_rd_q;
	assign sts.no_room      = ({2'b00, left} < need);
	assign sts.table_full   = (count_q == NULL_IDX);
	assign sts.out_free     = !out_valid_q || rsp.ready;

	assign rsp.valid           = out_valid_q;
	assign rsp.status          = out_status_q;
	assign rsp.payload_address = out_addr_q;
	assign rsp.granted_size    = out_size_q;

	// table memories: one write port each, registered read at cur_q
	always_ff @(posedge clk) begin
		off_rd_q   <= off_mem[cur_a];
		bytes_rd_q <= bytes_mem[cur_a];
		next_rd_q  <= next_mem[cur_a];
		free_rd_q  <= free_mem[cur_a];
		if (cmd.alloc_new) begin
			off_mem[cnt_a]   <= bump_q;
			bytes_mem[cnt_a] <= rounded_q[23:0];
		end
		if (cmd.alloc_new) begin
			next_mem[cnt_a] <= NULL_IDX;
		end else if (cmd.unlink && prev_valid_q) begin
			next_mem[prev_a] <= next_rd_q;
		end else if (cmd.release_blk) begin
			next_mem[cur_a] <= head_q;
		end
		if (cmd.alloc_new) begin
			free_mem[cnt_a] <= 1'b0;
		end else if (cmd.unlink || cmd.release_blk) begin
			free_mem[cur_a] <= cmd.release_blk;
		end
	end

	// request payload and walk pointers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q     <= req.kind;
			req_size_q <= req.request_size;
			addr_q     <= req.release_address;
			rounded_q  <= ({1'b0, req.request_size} + ffa_pkg::ALIGN_LOW) & ~ffa_pkg::ALIGN_LOW;
		end
		if (cmd.init) begin
			cur_q        <= (kind_q == ffa_pkg::KIND_ALLOC) ? head_q : '0;
			prev_q       <= NULL_IDX;
			prev_valid_q <= 1'b0;
		end else if (cmd.advance) begin
			prev_q       <= cur_q;
			prev_valid_q <= 1'b1;
			cur_q        <= (kind_q == ffa_pkg::KIND_ALLOC) ? next_rd_q : cur_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_q  <= ffa_pkg::POOL_RESET;
			bump_q  <= '0;
			count_q <= '0;
			head_q  <= NULL_IDX;
		end else begin
			if (cfg_we) begin
				pool_q <= cfg_wdata;
			end
			if (cmd.alloc_new) begin
				count_q <= count_q + 1'b1;
				bump_q  <= bump_q + need[23:0];
			end
			if (cmd.unlink && !prev_valid_q) begin
				head_q <= next_rd_q;
			end else if (cmd.release_blk) begin
				head_q <= cur_q;
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.wr_res) begin
			out_status_q <= cmd.st;
			case (cmd.src)
				ffa_pkg::SRC_HIT: begin
					out_addr_q <= payload_hit[23:0];
					out_size_q <= bytes_rd_q;
				end
				ffa_pkg::SRC_NEW: begin
					out_addr_q <= bump_q + ffa_pkg::HEADER_W[23:0];
					out_size_q <= rounded_q[23:0];
				end
				default: begin
					out_addr_q <= '0;
					out_size_q <= '0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	a_head_range: assert property (@(posedge clk) disable iff (!arst_n)
		head_q == NULL_IDX || head_q < count_q)
		else $error("free head outside block table");

	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= NULL_IDX)
		else $error("block count overflow");

	a_unlink_prev: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.unlink && prev_valid_q |-> prev_q < count_q && cur_q < count_q)
		else $error("unlink outside block table");

endmodule

/* rtl/core/first_fit_free_list_allocator.sv */
// -----------------------------------------------------------------------------
// first_fit_free_list_allocator
// First-fit allocator over a byte pool with an unsplit block free list.
// -----------------------------------------------------------------------------
// channel  dir  handshake       payload
// req      in   valid/ready     kind, request_size, release_address
// rsp      out  valid/ready     status, payload_address, granted_size
// cfg      in   cfg_we          cfg_wdata = pool_size
//
// One request at a time. Allocate walks the free list from its head and takes the first
// node that fits, or bumps a new block when no node fits. Free scans the block table from
// entry 0 for a match, else reports unknown. Zero size and null free answer without a walk.
// A new request waits in its start cycle while the previous result is still held.
// Reset clears pointers and counts; the table needs no clearing pass.
// -----------------------------------------------------------------------------
module first_fit_free_list_allocator #(
	parameter int unsigned MAX_BLOCKS = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [23:0] cfg_wdata,
	ffa_req_if.sink     req,
	ffa_rsp_if.source   rsp
);

	ffa_pkg::cmd_t cmd;
	ffa_pkg::sts_t sts;

	ffa_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.cmd    (cmd)
	);

	ffa_dp #(
		.MAX_BLOCKS (MAX_BLOCKS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req),
		.rsp       (rsp),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule
